// ===== hdl/ibdk_pkg.sv =====
// Shared types, widths and constants of the pair IBD kinship accumulator.
`default_nettype none

package ibdk_pkg;

    // Field widths, fixed by the transaction format
    localparam int SAMPLE_W   = 6;
    localparam int KIND_W     = 2;
    localparam int LEN_W      = 24;
    localparam int COUNT_W    = 16;
    localparam int SUM_W      = 24;
    localparam int Q24_W      = 24;
    localparam int INV_W      = 32;
    localparam int DEG_W      = 5;
    localparam int REC_W      = COUNT_W + 2 * SUM_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // Default sizing
    localparam int MAX_SAMPLES_DEF = 64;
    localparam int QUEUE_DEPTH_DEF = 2;

    // Item modes
    localparam logic MODE_ADD   = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    // Segment kinds that carry length
    localparam logic [KIND_W-1:0] KIND_IBD1 = 2'd1;
    localparam logic [KIND_W-1:0] KIND_IBD2 = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_INV_MAP_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KINSHIP_OFFSET = 2'd1;

    // Configuration reset values
    localparam logic [INV_W-1:0] INV_MAP_LENGTH_RST = 32'd1227133;
    localparam logic [Q24_W-1:0] KINSHIP_OFFSET_RST = 24'd23153;

    // Degree classes beyond the plain 0..7 range
    localparam logic signed [DEG_W-1:0] DEG_UNRELATED = -5'sd1;
    localparam logic signed [DEG_W-1:0] DEG_AT_LIMIT  = 5'sd8;

    // Degree thresholds, Q0.24
    localparam logic [Q24_W-1:0] DEG_LIMIT [8] = '{
        24'd7969178, 24'd2965821, 24'd1482910, 24'd741455,
        24'd370728,  24'd185364,  24'd92682,   24'd46341
    };

    // One classified item on its way from front to back
    typedef struct packed {
        logic                mode;
        logic                pair_ok;
        logic [SAMPLE_W-1:0] first_sample;
        logic [SAMPLE_W-1:0] second_sample;
        logic [KIND_W-1:0]   ibd_kind;
        logic [LEN_W-1:0]    seg_length;
    } t_item;

    localparam int ITEM_W = $bits(t_item);

    // Queue occupancy flags
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

`default_nettype wire

// ===== hdl/ibdk_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module ibdk_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ===== hdl/ibdk_front.sv =====
// Front end: accepts items and classifies the sample pair.
`default_nettype none

module ibdk_front
    import ibdk_pkg::*;
#(
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
    input  wire logic                start,
    input  wire logic                i_busy,
    input  wire logic                i_mode,
    input  wire logic [SAMPLE_W-1:0] i_first_sample,
    input  wire logic [SAMPLE_W-1:0] i_second_sample,
    input  wire logic [KIND_W-1:0]   i_ibd_kind,
    input  wire logic [LEN_W-1:0]    i_seg_length,
    output logic                     o_push,
    output t_item                    o_item
);

    // Wide enough to hold MAX_SAMPLES itself
    localparam int CMP_W = $clog2(MAX_SAMPLES + 1) > SAMPLE_W ?
                           $clog2(MAX_SAMPLES + 1) : SAMPLE_W + 1;
    localparam logic [CMP_W-1:0] SAMPLE_LIMIT = CMP_W'(MAX_SAMPLES);

    logic first_in_range;
    logic second_in_range;

    assign first_in_range  = CMP_W'(i_first_sample) < SAMPLE_LIMIT;
    assign second_in_range = CMP_W'(i_second_sample) < SAMPLE_LIMIT;

    assign o_push = start && !i_busy;

    always_comb begin
        o_item.mode          = i_mode;
        o_item.pair_ok       = first_in_range && second_in_range &&
                               (i_second_sample > i_first_sample);
        o_item.first_sample  = i_first_sample;
        o_item.second_sample = i_second_sample;
        o_item.ibd_kind      = i_ibd_kind;
        o_item.seg_length    = i_seg_length;
    end

endmodule

`default_nettype wire

// ===== hdl/ibdk_queue.sv =====
// Short FIFO that decouples the front end from the back end.
`default_nettype none

module ibdk_queue #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    input  wire logic             i_pop,
    output logic      [WIDTH-1:0] o_data,
    output ibdk_pkg::t_q_status   o_status
);

    localparam int PTR_W = DEPTH > 1 ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [WIDTH-1:0] r_slot [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count,  n_count;
    logic             do_push;
    logic             do_pop;

    assign do_push = i_push && (r_count != CNT_FULL);
    assign do_pop  = i_pop && (r_count != '0);

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

    assign o_data         = r_slot[r_rd_ptr];
    assign o_status.full  = (r_count == CNT_FULL);
    assign o_status.empty = (r_count == '0);

endmodule

`default_nettype wire

// ===== hdl/ibdk_back.sv =====
// Back end: clears the pair store, applies adds and evaluates queries.
`default_nettype none

module ibdk_back
    import ibdk_pkg::*;
#(
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire t_q_status               i_q_status,
    input  wire t_item                   i_item,
    output logic                         o_pop,
    output logic                         o_clearing,
    input  wire logic [INV_W-1:0]        i_inv_map_length,
    input  wire logic [Q24_W-1:0]        i_kinship_offset,
    output logic                         o_result_strobe,
    output logic                         o_present,
    output logic [COUNT_W-1:0]           o_segment_count,
    output logic [Q24_W-1:0]             o_kinship,
    output logic [Q24_W-1:0]             o_ibd2_fraction,
    output logic signed [DEG_W-1:0]      o_degree
);

    localparam int DEPTH  = MAX_SAMPLES * MAX_SAMPLES;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int W_W    = SUM_W + 2;
    localparam int PROD_W = W_W + INV_W;
    localparam int PHI_W  = PROD_W - 20 + 1;
    localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(DEPTH - 1);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_MUL1  = 3'd3;
    localparam logic [2:0] S_MUL2  = 3'd4;
    localparam logic [2:0] S_FINAL = 3'd5;

    logic [2:0]        r_state, n_state;
    logic [ADDR_W-1:0] r_clr_addr, n_clr_addr;
    logic              r_strobe, n_strobe;

    t_item                    r_item;
    logic [COUNT_W-1:0]       r_cnt;
    logic [SUM_W-1:0]         r_s1;
    logic [SUM_W-1:0]         r_s2;
    logic [PROD_W-1:0]        r_prod;
    logic [Q24_W-1:0]         r_phi;
    logic                     r_present;
    logic [COUNT_W-1:0]       r_count_out;
    logic [Q24_W-1:0]         r_kinship;
    logic [Q24_W-1:0]         r_fraction;
    logic signed [DEG_W-1:0]  r_degree;

    logic              ram_wr_en;
    logic [ADDR_W-1:0] ram_wr_addr;
    logic [REC_W-1:0]  ram_wr_data;
    logic              ram_rd_en;
    logic [REC_W-1:0]  ram_rd_data;

    logic [REC_W-1:0]        rec;
    logic [COUNT_W-1:0]      rec_cnt;
    logic [SUM_W-1:0]        rec_s1;
    logic [SUM_W-1:0]        rec_s2;
    logic [COUNT_W-1:0]      new_cnt;
    logic [SUM_W-1:0]        new_s1;
    logic [SUM_W-1:0]        new_s2;
    logic [W_W-1:0]          w_sum;
    logic [PHI_W-1:0]        phi_sum;
    logic [Q24_W-1:0]        phi_sat;
    logic [Q24_W-1:0]        frac_sat;
    logic signed [DEG_W-1:0] deg_class;

    function automatic logic [ADDR_W-1:0] slot_of(input t_item it);
        return ADDR_W'(it.first_sample) * ADDR_W'(MAX_SAMPLES) + ADDR_W'(it.second_sample);
    endfunction

    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] s,
                                                  input logic [LEN_W-1:0] v);
        logic [SUM_W:0] t;
        t = {1'b0, s} + (SUM_W + 1)'(v);
        return t[SUM_W] ? '1 : t[SUM_W-1:0];
    endfunction

    ibdk_ram #(
        .WIDTH(REC_W),
        .DEPTH(DEPTH)
    ) u_store (
        .i_clk    (i_clk),
        .i_wr_en  (ram_wr_en),
        .i_wr_addr(ram_wr_addr),
        .i_wr_data(ram_wr_data),
        .i_rd_en  (ram_rd_en),
        .i_rd_addr(slot_of(i_item)),
        .o_rd_data(ram_rd_data)
    );

    // Record read back in S_READ; an invalid pair reads as empty
    assign rec     = r_item.pair_ok ? ram_rd_data : '0;
    assign rec_cnt = rec[REC_W-1 -: COUNT_W];
    assign rec_s1  = rec[2*SUM_W-1 -: SUM_W];
    assign rec_s2  = rec[SUM_W-1:0];

    always_comb begin
        new_cnt = (rec_cnt == '1) ? rec_cnt : rec_cnt + 1'b1;
        new_s1  = rec_s1;
        new_s2  = rec_s2;
        if (r_item.ibd_kind == KIND_IBD1) begin
            new_s1 = sat_add(rec_s1, r_item.seg_length);
        end else if (r_item.ibd_kind == KIND_IBD2) begin
            new_s2 = sat_add(rec_s2, r_item.seg_length);
        end
    end

    assign w_sum    = W_W'(r_s1) + {1'b0, r_s2, 1'b0};
    assign phi_sum  = PHI_W'(r_prod[PROD_W-1:20]) + PHI_W'(i_kinship_offset);
    assign phi_sat  = (|phi_sum[PHI_W-1:Q24_W]) ? '1 : phi_sum[Q24_W-1:0];
    assign frac_sat = (|r_prod[PROD_W-1:Q24_W+18]) ? '1 : r_prod[Q24_W+17:18];

    always_comb begin
        deg_class = DEG_AT_LIMIT;
        for (int d = 7; d >= 0; d--) begin
            if (r_phi > DEG_LIMIT[d]) begin
                deg_class = DEG_W'(d);
            end
        end
        if (r_phi < DEG_LIMIT[7]) begin
            deg_class = DEG_UNRELATED;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        n_strobe   = 1'b0;
        o_pop      = 1'b0;
        ram_rd_en  = 1'b0;
        ram_wr_en  = 1'b0;
        ram_wr_addr = slot_of(r_item);
        ram_wr_data = {new_cnt, new_s1, new_s2};
        unique case (r_state)
            S_CLEAR: begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = r_clr_addr;
                ram_wr_data = '0;
                n_clr_addr  = r_clr_addr + 1'b1;
                if (r_clr_addr == ADDR_LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (!i_q_status.empty) begin
                    o_pop     = 1'b1;
                    ram_rd_en = 1'b1;
                    n_state   = S_READ;
                end
            end
            S_READ: begin
                if (r_item.mode == MODE_ADD) begin
                    ram_wr_en = r_item.pair_ok;
                    n_state   = S_IDLE;
                end else if (rec_cnt == '0) begin
                    n_strobe = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    n_state = S_MUL1;
                end
            end
            S_MUL1:  n_state = S_MUL2;
            S_MUL2:  n_state = S_FINAL;
            S_FINAL: begin
                n_strobe = 1'b1;
                n_state  = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_strobe   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_strobe   <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_item <= i_item;
        end
        unique case (r_state)
            S_READ: begin
                r_cnt       <= rec_cnt;
                r_s1        <= rec_s1;
                r_s2        <= rec_s2;
                r_present   <= 1'b0;
                r_count_out <= '0;
                r_kinship   <= '0;
                r_fraction  <= '0;
                r_degree    <= '0;
            end
            S_MUL1: begin
                r_prod <= PROD_W'(w_sum) * PROD_W'(i_inv_map_length);
            end
            S_MUL2: begin
                r_phi  <= phi_sat;
                r_prod <= PROD_W'(r_s2) * PROD_W'(i_inv_map_length);
            end
            S_FINAL: begin
                r_present   <= 1'b1;
                r_count_out <= r_cnt;
                r_kinship   <= r_phi;
                r_fraction  <= frac_sat;
                r_degree    <= deg_class;
            end
            default: begin
            end
        endcase
    end

    assign o_clearing      = (r_state == S_CLEAR);
    assign o_result_strobe = r_strobe;
    assign o_present       = r_present;
    assign o_segment_count = r_count_out;
    assign o_kinship       = r_kinship;
    assign o_ibd2_fraction = r_fraction;
    assign o_degree        = r_degree;

endmodule

`default_nettype wire

// ===== hdl/pair_ibd_kinship_accumulator.sv =====
// Top level of the pair IBD kinship accumulator: front end, queue, back end, registers.
//
//  Channel   Direction  Handshake                      Payload
//  -------   ---------  -----------------------------  -----------------------------------
//  item      in         start high, busy low           i_mode, i_first_sample,
//                                                      i_second_sample, i_ibd_kind,
//                                                      i_seg_length
//  result    out        o_result_strobe, one cycle     o_present, o_segment_count,
//                                                      o_kinship, o_ibd2_fraction, o_degree
//  config    in         i_cfg_wr_en, no wait           i_cfg_index, i_cfg_data
//
//  Back-end steps per transaction: an add pops and reads, then writes back; a query of a
//  present pair pops, reads, runs two multiplies in turn and classifies, then strobes;
//  a query of an absent pair pops and reads, then strobes. The queue registers each
//  accepted transaction before the back end can pop it.
//  After reset a clearing pass writes every entry, MAX_SAMPLES*MAX_SAMPLES
//  of them (4096 by default), with busy held high; register writes still land.
//  busy also rises while the front queue is full. Results cannot be held off.
`default_nettype none

module pair_ibd_kinship_accumulator
    import ibdk_pkg::*;
#(
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic                  i_mode,
    input  wire logic [SAMPLE_W-1:0]   i_first_sample,
    input  wire logic [SAMPLE_W-1:0]   i_second_sample,
    input  wire logic [KIND_W-1:0]     i_ibd_kind,
    input  wire logic [LEN_W-1:0]      i_seg_length,
    input  wire logic                  i_cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                       o_result_strobe,
    output logic                       o_present,
    output logic [COUNT_W-1:0]         o_segment_count,
    output logic [Q24_W-1:0]           o_kinship,
    output logic [Q24_W-1:0]           o_ibd2_fraction,
    output logic signed [DEG_W-1:0]    o_degree
);

    logic              push;
    t_item             front_item;
    t_item             queue_item;
    logic [ITEM_W-1:0] queue_data;
    t_q_status         q_status;
    logic              pop;
    logic              clearing;

    logic [INV_W-1:0]  r_inv_map_length;
    logic [Q24_W-1:0]  r_kinship_offset;

    // Hold off new transactions while the store clears or the queue is full
    assign busy = clearing || q_status.full;

    // Configuration registers; an index beyond the list is dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv_map_length <= INV_MAP_LENGTH_RST;
            r_kinship_offset <= KINSHIP_OFFSET_RST;
        end else if (i_cfg_wr_en) begin
            if (i_cfg_index == CFG_INV_MAP_LENGTH) begin
                r_inv_map_length <= i_cfg_data;
            end else if (i_cfg_index == CFG_KINSHIP_OFFSET) begin
                r_kinship_offset <= i_cfg_data[Q24_W-1:0];
            end
        end
    end

    // Front end: take the transaction and mark whether the pair is usable
    ibdk_front #(
        .MAX_SAMPLES(MAX_SAMPLES)
    ) u_front (
        .start          (start),
        .i_busy         (busy),
        .i_mode         (i_mode),
        .i_first_sample (i_first_sample),
        .i_second_sample(i_second_sample),
        .i_ibd_kind     (i_ibd_kind),
        .i_seg_length   (i_seg_length),
        .o_push         (push),
        .o_item         (front_item)
    );

    // Queue: lets the front keep taking transactions while the back works
    ibdk_queue #(
        .WIDTH(ITEM_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_item),
        .i_pop   (pop),
        .o_data  (queue_data),
        .o_status(q_status)
    );

    assign queue_item = queue_data;

    // Back end: owns the pair store, the multiplier and the result registers
    ibdk_back #(
        .MAX_SAMPLES(MAX_SAMPLES)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_status      (q_status),
        .i_item          (queue_item),
        .o_pop           (pop),
        .o_clearing      (clearing),
        .i_inv_map_length(r_inv_map_length),
        .i_kinship_offset(r_kinship_offset),
        .o_result_strobe (o_result_strobe),
        .o_present       (o_present),
        .o_segment_count (o_segment_count),
        .o_kinship       (o_kinship),
        .o_ibd2_fraction (o_ibd2_fraction),
        .o_degree        (o_degree)
    );

endmodule

`default_nettype wire

// ===== hdl/ibdk_checker.sv =====
// Port-level checker for the accumulator, bound to its top level.
`default_nettype none

module ibdk_checker
    import ibdk_pkg::*;
(
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  busy,
    input wire logic                  o_result_strobe,
    input wire logic                  o_present,
    input wire logic [COUNT_W-1:0]    o_segment_count,
    input wire logic [Q24_W-1:0]      o_kinship,
    input wire logic [Q24_W-1:0]      o_ibd2_fraction,
    input wire logic signed [DEG_W-1:0] o_degree
);

    // The store clearing pass must hold off transactions right after reset
    a_busy_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> busy)
        else $error("busy low straight after reset");

    // Each strobe is set from S_READ or S_FINAL and the next query must pass S_IDLE first, so strobes never abut
    a_strobe_isolated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe |=> !o_result_strobe)
        else $error("result strobes in consecutive cycles");

    a_absent_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_strobe && !o_present) |->
            (o_segment_count == '0 && o_kinship == '0 &&
             o_ibd2_fraction == '0 && o_degree == '0))
        else $error("absent pair with nonzero fields");

    a_present_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_strobe && o_present) |-> (o_segment_count != '0))
        else $error("present pair with zero count");

    a_unrelated_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_strobe && o_present && o_degree == DEG_UNRELATED) |->
            (o_kinship < DEG_LIMIT[7]))
        else $error("unrelated class above lowest threshold");

endmodule

bind pair_ibd_kinship_accumulator ibdk_checker u_ibdk_checker (.*);

`default_nettype wire

// ===== verif/pair_ibd_kinship_accumulator_tb.sv =====
// Self-checking testbench for the pair IBD kinship accumulator: directed table, then random traffic.
`timescale 1ns / 100ps

module pair_ibd_kinship_accumulator_tb;
    import ibdk_pkg::*;

    // ------------------------------------------------------------------
    // Timing and run-length figures
    // ------------------------------------------------------------------
    localparam int CLK_PERIOD      = 12;
    localparam int RESET_CYCLES    = 6;
    // Longest back-end occupancy is a query of a present pair, and the front queue
    // holds 2 more transactions, so DRAIN_CYCLES is enough to clear any add still
    // in flight once the last result has come.
    localparam int DRAIN_CYCLES    = 32;
    localparam int IDLE_WAIT_LIMIT = 2000;
    localparam int ITEMS_PER_PHASE = 87;
    localparam int RANDOM_PHASES   = 6;
    // Slowest correct run: the clearing pass, ~550 transactions at up to a full
    // query's back-end occupancy each plus sender gaps, and a drain ahead of each
    // table register write and each random phase (some 30 writes); allow 2 ms.
    localparam int WATCHDOG_NS     = 2_000_000;

    localparam int PAIR_SLOTS = MAX_SAMPLES_DEF * MAX_SAMPLES_DEF;

    // Register reset values and degree bounds, written from the spec rather than
    // taken from the package so that a wrong package constant is caught
    localparam logic [INV_W-1:0] INV_RESET    = 32'd1227133;
    localparam logic [Q24_W-1:0] OFFSET_RESET = 24'd23153;
    localparam logic [Q24_W-1:0] Q24_FULL     = 24'hFFFFFF;
    localparam logic [COUNT_W-1:0] COUNT_FULL = 16'hFFFF;
    // Index d holds the lower bound of degree d; [7] is the unrelated cut-off
    localparam logic [7:0][Q24_W-1:0] DEG_BOUND = {
        24'd46341,  24'd92682,  24'd185364,  24'd370728,
        24'd741455, 24'd1482910, 24'd2965821, 24'd7969178
    };

    // Kinds that carry no length, and register indexes past the end of the map
    localparam logic [KIND_W-1:0]    KIND_PLAIN  = 2'd0;
    localparam logic [KIND_W-1:0]    KIND_SPARE  = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

    // ------------------------------------------------------------------
    // Types
    // ------------------------------------------------------------------
    typedef struct packed {
        logic                mode;
        logic [SAMPLE_W-1:0] first_sample;
        logic [SAMPLE_W-1:0] second_sample;
        logic [KIND_W-1:0]   ibd_kind;
        logic [LEN_W-1:0]    seg_length;
    } t_seg_item;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [SUM_W-1:0]   ibd1_sum;
        logic [SUM_W-1:0]   ibd2_sum;
    } t_pair_rec;

    typedef struct packed {
        logic                    present;
        logic [COUNT_W-1:0]      segment_count;
        logic [Q24_W-1:0]        kinship;
        logic [Q24_W-1:0]        ibd2_fraction;
        logic signed [DEG_W-1:0] degree;
    } t_kin_result;

    typedef struct packed {
        t_kin_result         res;
        logic [SAMPLE_W-1:0] first_sample;
        logic [SAMPLE_W-1:0] second_sample;
    } t_pending;

    typedef enum logic {ROW_ITEM, ROW_CFG} t_row_op;

    typedef struct packed {
        t_row_op                op;
        t_seg_item              item;
        int unsigned            reps;
        bit                     has_answer;
        t_kin_result            answer;
        logic [CFG_IDX_W-1:0]   cfg_index;
        logic [CFG_DATA_W-1:0]  cfg_data;
    } t_script_row;

    // ------------------------------------------------------------------
    // Block connections
    // ------------------------------------------------------------------
    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    start;
    logic                    busy;
    logic                    i_mode;
    logic [SAMPLE_W-1:0]     i_first_sample;
    logic [SAMPLE_W-1:0]     i_second_sample;
    logic [KIND_W-1:0]       i_ibd_kind;
    logic [LEN_W-1:0]        i_seg_length;
    logic                    i_cfg_wr_en;
    logic [CFG_IDX_W-1:0]    i_cfg_index;
    logic [CFG_DATA_W-1:0]   i_cfg_data;
    logic                    o_result_strobe;
    logic                    o_present;
    logic [COUNT_W-1:0]      o_segment_count;
    logic [Q24_W-1:0]        o_kinship;
    logic [Q24_W-1:0]        o_ibd2_fraction;
    logic signed [DEG_W-1:0] o_degree;

    pair_ibd_kinship_accumulator u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_mode          (i_mode),
        .i_first_sample  (i_first_sample),
        .i_second_sample (i_second_sample),
        .i_ibd_kind      (i_ibd_kind),
        .i_seg_length    (i_seg_length),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_result_strobe (o_result_strobe),
        .o_present       (o_present),
        .o_segment_count (o_segment_count),
        .o_kinship       (o_kinship),
        .o_ibd2_fraction (o_ibd2_fraction),
        .o_degree        (o_degree)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Predictor state: a private copy of the pair store and both registers
    // ------------------------------------------------------------------
    t_pair_rec        pair_rec [0:PAIR_SLOTS-1];
    logic [INV_W-1:0] inv_map_len;
    logic [Q24_W-1:0] kin_offset;
    t_pending         pending_results [$];

    // Driver side: a typed-in answer travels with the transaction it belongs to
    bit               row_has_answer;
    t_kin_result      row_answer;
    int unsigned      gap_pct;

    t_script_row      script [$];

    // Tallies for the closing summary
    int unsigned err_count;
    int unsigned n_adds;
    int unsigned n_queries;
    int unsigned n_checked;
    int unsigned n_absent;
    int unsigned n_cfg_writes;
    logic [9:0]  deg_seen;

    // Saturating 24-bit length sum
    function automatic logic [SUM_W-1:0] sum_sat(input logic [SUM_W-1:0] acc,
                                                 input logic [LEN_W-1:0] len);
        logic [SUM_W:0] wide;
        wide = {1'b0, acc} + {1'b0, len};
        return wide[SUM_W] ? Q24_FULL : wide[SUM_W-1:0];
    endfunction

    // Work out what a query of this record returns under the current registers
    function automatic t_kin_result pair_summary(input t_pair_rec rec);
        logic [63:0] weighted;
        logic [63:0] kin_wide;
        logic [63:0] frac_wide;
        t_kin_result res;
        res = '0;
        if (rec.count == '0)
            return res;
        // IBD1 counts a quarter and IBD2 a half: weigh IBD2 double, shift 20
        weighted  = {40'd0, rec.ibd1_sum} + ({40'd0, rec.ibd2_sum} << 1);
        kin_wide  = ((weighted * {32'd0, inv_map_len}) >> 20) + {40'd0, kin_offset};
        frac_wide = ({40'd0, rec.ibd2_sum} * {32'd0, inv_map_len}) >> 18;
        res.present       = 1'b1;
        res.segment_count = rec.count;
        res.kinship       = (kin_wide > {40'd0, Q24_FULL}) ? Q24_FULL : kin_wide[Q24_W-1:0];
        res.ibd2_fraction = (frac_wide > {40'd0, Q24_FULL}) ? Q24_FULL : frac_wide[Q24_W-1:0];
        if (res.kinship < DEG_BOUND[7]) begin
            res.degree = DEG_UNRELATED;
        end else begin
            // Walk from the loosest bound up so the closest degree wins
            res.degree = DEG_AT_LIMIT;
            for (int d = 7; d >= 0; d--)
                if (res.kinship > DEG_BOUND[d])
                    res.degree = d[DEG_W-1:0];
        end
        return res;
    endfunction

    // Fold one accepted transaction into the private store, queue any result
    task automatic absorb_item(input t_seg_item it, input bit has_answer,
                               input t_kin_result answer);
        int unsigned slot;
        bit          ordered;
        t_pair_rec   rec;
        t_pending    pend;
        // Indexes are 6 bits with 64 samples, so only the ordering can disqualify
        ordered = it.second_sample > it.first_sample;
        slot    = it.first_sample * MAX_SAMPLES_DEF + it.second_sample;
        rec     = ordered ? pair_rec[slot] : '0;
        if (it.mode == MODE_ADD) begin
            n_adds++;
            if (ordered) begin
                if (rec.count != COUNT_FULL)
                    rec.count++;
                if (it.ibd_kind == KIND_IBD1)
                    rec.ibd1_sum = sum_sat(rec.ibd1_sum, it.seg_length);
                else if (it.ibd_kind == KIND_IBD2)
                    rec.ibd2_sum = sum_sat(rec.ibd2_sum, it.seg_length);
                pair_rec[slot] = rec;
            end
        end else begin
            n_queries++;
            pend.res           = has_answer ? answer : pair_summary(rec);
            pend.first_sample  = it.first_sample;
            pend.second_sample = it.second_sample;
            pending_results    = {pending_results, pend};
        end
    endtask

    // Compare one strobed result with the oldest outstanding expectation
    task automatic check_result();
        t_kin_result got;
        t_pending    pend;
        got.present       = o_present;
        got.segment_count = o_segment_count;
        got.kinship       = o_kinship;
        got.ibd2_fraction = o_ibd2_fraction;
        got.degree        = o_degree;
        if (pending_results.size() == 0) begin
            err_count++;
            if (err_count <= 10)
                $display("%0t: result with nothing outstanding: present=%0d count=%0d kin=%h frac=%h deg=%0d",
                         $realtime, got.present, got.segment_count, got.kinship,
                         got.ibd2_fraction, got.degree);
            return;
        end
        pend = pending_results.pop_front();
        n_checked++;
        if (!pend.res.present)
            n_absent++;
        else
            deg_seen[int'(pend.res.degree) + 1] = 1'b1;
        if (got.present !== pend.res.present || got.segment_count !== pend.res.segment_count ||
            got.kinship !== pend.res.kinship || got.ibd2_fraction !== pend.res.ibd2_fraction ||
            got.degree !== pend.res.degree) begin
            err_count++;
            if (err_count <= 10) begin
                $display("%0t: pair (%0d,%0d) mismatch", $realtime,
                         pend.first_sample, pend.second_sample);
                $display("    expected present=%0d count=%0d kin=%h frac=%h deg=%0d",
                         pend.res.present, pend.res.segment_count, pend.res.kinship,
                         pend.res.ibd2_fraction, pend.res.degree);
                $display("    actual   present=%0d count=%0d kin=%h frac=%h deg=%0d",
                         got.present, got.segment_count, got.kinship,
                         got.ibd2_fraction, got.degree);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Monitor: everything is sampled at the rising edge, before the block's
    // own updates land. Check first, then absorb the transaction and any
    // register write taken at this same edge.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            if (o_result_strobe === 1'b1)
                check_result();
            if (start === 1'b1 && busy === 1'b0)
                absorb_item('{i_mode, i_first_sample, i_second_sample, i_ibd_kind,
                              i_seg_length}, row_has_answer, row_answer);
            if (i_cfg_wr_en === 1'b1) begin
                case (i_cfg_index)
                    CFG_INV_MAP_LENGTH: inv_map_len = i_cfg_data[INV_W-1:0];
                    CFG_KINSHIP_OFFSET: kin_offset  = i_cfg_data[Q24_W-1:0];
                    default: ;  // writes past the register map are dropped
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Driver tasks: each one starts and ends just after a rising edge and
    // changes inputs only at falling edges
    // ------------------------------------------------------------------

    // Offer one transaction, holding start until the block takes it
    task automatic send_item(input t_seg_item it, input bit has_answer,
                             input t_kin_result answer);
        while ($urandom_range(0, 99) < gap_pct) begin
            @(negedge i_clk);
            start <= 1'b0;
            @(posedge i_clk);
        end
        @(negedge i_clk);
        start           <= 1'b1;
        i_mode          <= it.mode;
        i_first_sample  <= it.first_sample;
        i_second_sample <= it.second_sample;
        i_ibd_kind      <= it.ibd_kind;
        i_seg_length    <= it.seg_length;
        row_has_answer  <= has_answer;
        row_answer      <= answer;
        @(posedge i_clk);
        while (busy !== 1'b0)
            @(posedge i_clk);
    endtask

    // Drop start, wait for every outstanding result, then let trailing adds drain
    task automatic wait_idle();
        int unsigned waited;
        @(negedge i_clk);
        start <= 1'b0;
        @(posedge i_clk);
        waited = 0;
        while (pending_results.size() != 0 && waited < IDLE_WAIT_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (pending_results.size() != 0) begin
            err_count++;
            $display("%0t: %0d expected results never arrived", $realtime,
                     pending_results.size());
            pending_results.delete();
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        @(posedge i_clk);
        n_cfg_writes++;
    endtask

    // ------------------------------------------------------------------
    // Directed table builders
    // ------------------------------------------------------------------
    function automatic void put_item(input logic mode, input logic [SAMPLE_W-1:0] lo,
                                     input logic [SAMPLE_W-1:0] hi,
                                     input logic [KIND_W-1:0] kind,
                                     input logic [LEN_W-1:0] len, input int unsigned reps);
        t_script_row row;
        row      = '0;
        row.op   = ROW_ITEM;
        row.item = '{mode, lo, hi, kind, len};
        row.reps = reps;
        script   = {script, row};
    endfunction

    // Query whose answer is known without working it out
    function automatic void put_check(input logic [SAMPLE_W-1:0] lo,
                                      input logic [SAMPLE_W-1:0] hi, input logic present,
                                      input logic [COUNT_W-1:0] count,
                                      input logic [Q24_W-1:0] kin,
                                      input logic [Q24_W-1:0] frac,
                                      input logic signed [DEG_W-1:0] deg);
        t_script_row row;
        row            = '0;
        row.op         = ROW_ITEM;
        row.item       = '{MODE_QUERY, lo, hi, KIND_PLAIN, 24'd0};
        row.reps       = 1;
        row.has_answer = 1'b1;
        row.answer     = '{present, count, kin, frac, deg};
        script         = {script, row};
    endfunction

    function automatic void put_cfg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
        t_script_row row;
        row           = '0;
        row.op        = ROW_CFG;
        row.cfg_index = idx;
        row.cfg_data  = data;
        script        = {script, row};
    endfunction

    // ------------------------------------------------------------------
    // Random traffic: mostly a small pool of live pairs so that sums build up
    // and same-pair hazards are frequent, with unordered and stray pairs mixed in
    // ------------------------------------------------------------------
    task automatic run_random_phase(input int unsigned n_items);
        logic [SAMPLE_W-1:0] pool_lo [8];
        logic [SAMPLE_W-1:0] pool_hi [8];
        int unsigned         pool_n;
        int unsigned         pick;
        int unsigned         sel;
        t_seg_item           it;
        pool_n = $urandom_range(2, 8);
        for (int k = 0; k < pool_n; k++) begin
            pool_lo[k] = SAMPLE_W'($urandom_range(0, 62));
            pool_hi[k] = SAMPLE_W'($urandom_range(int'(pool_lo[k]) + 1, 63));
        end
        for (int k = 0; k < n_items; k++) begin
            it.mode = ($urandom_range(0, 99) < 30) ? MODE_QUERY : MODE_ADD;
            pick = $urandom_range(0, 99);
            if (pick < 65) begin
                sel = $urandom_range(0, pool_n - 1);
                it.first_sample  = pool_lo[sel];
                it.second_sample = pool_hi[sel];
            end else if (pick < 80) begin
                it.first_sample  = SAMPLE_W'($urandom_range(0, 62));
                it.second_sample = SAMPLE_W'($urandom_range(int'(it.first_sample) + 1, 63));
            end else if (pick < 92) begin
                // unordered or equal pair: add dropped, query absent
                it.first_sample  = SAMPLE_W'($urandom_range(0, 63));
                it.second_sample = SAMPLE_W'($urandom_range(0, int'(it.first_sample)));
            end else begin
                it.first_sample  = SAMPLE_W'($urandom_range(0, 63));
                it.second_sample = SAMPLE_W'($urandom_range(0, 63));
            end
            sel = $urandom_range(0, 9);
            it.ibd_kind = (sel < 4) ? KIND_IBD1 : (sel < 8) ? KIND_IBD2 :
                          (sel == 8) ? KIND_PLAIN : KIND_SPARE;
            // Segments of realistic length mostly, with short and full-range ones
            sel = $urandom_range(0, 99);
            if (sel < 75)
                it.seg_length = LEN_W'($urandom_range(0, 150 * 1024));
            else if (sel < 90)
                it.seg_length = LEN_W'($urandom_range(0, 1024));
            else
                it.seg_length = LEN_W'($urandom_range(0, 24'hFFFFFF));
            send_item(it, 1'b0, '0);
        end
    endtask

    // ------------------------------------------------------------------
    // Watchdog
    // ------------------------------------------------------------------
    initial begin
        #(WATCHDOG_NS);
        $display("%0t: run timed out, %0d results outstanding", $realtime,
                 pending_results.size());
        $display("pair_ibd_kinship_accumulator_tb failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        logic [INV_W-1:0]      inv_pick;
        logic [CFG_DATA_W-1:0] off_pick;
        t_script_row           row;

        // Hold every input at a known value and the block in reset
        i_rst_n         = 1'b0;
        start           = 1'b0;
        i_mode          = MODE_ADD;
        i_first_sample  = '0;
        i_second_sample = '0;
        i_ibd_kind      = KIND_PLAIN;
        i_seg_length    = '0;
        i_cfg_wr_en     = 1'b0;
        i_cfg_index     = CFG_INV_MAP_LENGTH;
        i_cfg_data      = '0;
        row_has_answer  = 1'b0;
        row_answer      = '0;
        gap_pct         = 0;
        err_count       = 0;
        n_adds          = 0;
        n_queries       = 0;
        n_checked       = 0;
        n_absent        = 0;
        n_cfg_writes    = 0;
        deg_seen        = '0;
        inv_map_len     = INV_RESET;
        kin_offset      = OFFSET_RESET;
        for (int s = 0; s < PAIR_SLOTS; s++)
            pair_rec[s] = '0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table. The first query lands during the clearing pass and
        // simply waits on busy.
        put_check(6'd0, 6'd1, 1'b0, '0, '0, '0, '0);
        put_item(MODE_ADD, 6'd0, 6'd1, KIND_IBD1, 24'd0, 1);
        put_item(MODE_QUERY, 6'd0, 6'd1, KIND_PLAIN, 24'd0, 1);
        put_item(MODE_ADD, 6'd62, 6'd63, KIND_IBD2, 24'hFFFFFF, 1);
        put_item(MODE_QUERY, 6'd62, 6'd63, KIND_SPARE, 24'hFFFFFF, 1);
        // Equal and reversed pairs: adds dropped, queries absent
        put_item(MODE_ADD, 6'd63, 6'd63, KIND_IBD1, 24'hFFFFFF, 1);
        put_check(6'd63, 6'd63, 1'b0, '0, '0, '0, '0);
        put_item(MODE_ADD, 6'd40, 6'd3, KIND_IBD2, 24'h0004D2, 1);
        put_check(6'd40, 6'd3, 1'b0, '0, '0, '0, '0);
        // Kinds without length only bump the count
        put_item(MODE_ADD, 6'd7, 6'd8, KIND_SPARE, 24'hABCDEF, 1);
        put_item(MODE_ADD, 6'd7, 6'd8, KIND_PLAIN, 24'hFFFFFF, 1);
        put_item(MODE_QUERY, 6'd7, 6'd8, KIND_IBD1, 24'd0, 1);
        // Both length sums run into saturation
        put_item(MODE_ADD, 6'd20, 6'd21, KIND_IBD1, 24'hFFFFFF, 2);
        put_item(MODE_ADD, 6'd20, 6'd21, KIND_IBD2, 24'h800000, 2);
        put_item(MODE_QUERY, 6'd20, 6'd21, KIND_PLAIN, 24'd0, 1);
        // A fresh pair with plain adds only: count grows, both sums stay at zero
        put_item(MODE_ADD, 6'd5, 6'd6, KIND_PLAIN, 24'd0, 4);
        put_check(6'd5, 6'd6, 1'b1, 16'd4, OFFSET_RESET, '0, DEG_UNRELATED);
        // Kinship sitting exactly on the lowest bound
        put_cfg(CFG_KINSHIP_OFFSET, 32'd46341);
        put_check(6'd5, 6'd6, 1'b1, 16'd4, 24'd46341, '0, DEG_AT_LIMIT);
        // Both registers at their maximum: kinship saturates, and so does the IBD2 fraction where there is IBD2 length
        put_cfg(CFG_KINSHIP_OFFSET, 32'hFFFFFFFF);
        put_cfg(CFG_INV_MAP_LENGTH, 32'hFFFFFFFF);
        put_check(6'd5, 6'd6, 1'b1, 16'd4, Q24_FULL, '0, 5'sd0);
        put_check(6'd62, 6'd63, 1'b1, 16'd1, Q24_FULL, Q24_FULL, 5'sd0);
        // Both registers at zero, then writes past the map that must not land
        put_cfg(CFG_INV_MAP_LENGTH, 32'd0);
        put_cfg(CFG_KINSHIP_OFFSET, 32'd0);
        put_check(6'd62, 6'd63, 1'b1, 16'd1, '0, '0, DEG_UNRELATED);
        put_cfg(CFG_SPARE_2, 32'hFFFFFFFF);
        put_cfg(CFG_SPARE_3, 32'hA5A5A5A5);
        put_check(6'd62, 6'd63, 1'b1, 16'd1, '0, '0, DEG_UNRELATED);
        put_cfg(CFG_INV_MAP_LENGTH, INV_RESET);
        put_cfg(CFG_KINSHIP_OFFSET, {8'd0, OFFSET_RESET});
        put_item(MODE_QUERY, 6'd20, 6'd21, KIND_IBD2, 24'd0, 1);

        // Walk the table; register writes only once the block has gone quiet
        foreach (script[r]) begin
            row = script[r];
            if (row.op == ROW_CFG) begin
                wait_idle();
                cfg_write(row.cfg_index, row.cfg_data);
            end else begin
                repeat (row.reps)
                    send_item(row.item, row.has_answer, row.answer);
            end
        end

        // Random phases: sender idles 29 in 100, then 49 in 100, then never.
        // Each phase gets its own register setting, extremes included.
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            gap_pct = (phase < 2) ? 29 : (phase < 4) ? 49 : 0;
            wait_idle();
            case (phase)
                0: begin inv_pick = INV_RESET;                       off_pick = $urandom_range(0, 100000); end
                1: begin inv_pick = $urandom;                        off_pick = $urandom; end
                2: begin inv_pick = $urandom_range(600000, 2500000); off_pick = 32'd0; end
                3: begin inv_pick = 32'hFFFFFFFF;                    off_pick = {8'd0, OFFSET_RESET}; end
                4: begin inv_pick = 32'd0;                           off_pick = $urandom_range(0, 200000); end
                default: begin inv_pick = INV_RESET;                 off_pick = 32'hFFFFFFFF; end
            endcase
            cfg_write(CFG_INV_MAP_LENGTH, inv_pick);
            cfg_write(CFG_KINSHIP_OFFSET, off_pick);
            cfg_write(($urandom_range(0, 1) != 0) ? CFG_SPARE_2 : CFG_SPARE_3, $urandom);
            run_random_phase(ITEMS_PER_PHASE);
        end

        wait_idle();

        $display("Covered %0d adds and %0d queries; %0d results checked, %0d of them absent pairs.",
                 n_adds, n_queries, n_checked, n_absent);
        $display("Made %0d register writes; %0d of 10 degree classes were exercised.",
                 n_cfg_writes, $countones(deg_seen));
        if (err_count == 0) begin
            $display("pair_ibd_kinship_accumulator_tb passed");
        end else begin
            $display("%0d errors", err_count);
            $display("pair_ibd_kinship_accumulator_tb failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/ibdk_pkg.sv
hdl/ibdk_ram.sv
hdl/ibdk_front.sv
hdl/ibdk_queue.sv
hdl/ibdk_back.sv
hdl/pair_ibd_kinship_accumulator.sv
hdl/ibdk_checker.sv
verif/pair_ibd_kinship_accumulator_tb.sv
